// ===== design/hav_pkg.sv =====
// Package for the haversine distance pipeline: formats, constants, CORDIC arctangent table.
// Depends on nothing.
package hav_pkg;
  localparam int Stages = 24;
  localparam int NStg = (Stages > 32) ? 32 : Stages;
  localparam int DW = 40;
  localparam logic signed [DW-1:0] GainInv = 40'sd652032874;
  localparam logic signed [DW-1:0] OneQ = 40'sd1073741824;
  localparam logic signed [DW-1:0] HalfPi = 40'sd1686629713;
  localparam logic [31:0] PiQ = 32'd3373259426;
  localparam logic [24:0] DistMax = 25'd20015087;
  localparam logic signed [31:0] LatMax = 32'sd900000000;

  typedef logic signed [DW-1:0] q_t;

  function automatic q_t atan_q(input int i);
    unique case (i)
      0: atan_q = 40'sd843314856;
      1: atan_q = 40'sd497837829;
      2: atan_q = 40'sd263043836;
      3: atan_q = 40'sd133525158;
      4: atan_q = 40'sd67021686;
      5: atan_q = 40'sd33543515;
      6: atan_q = 40'sd16775850;
      7: atan_q = 40'sd8388437;
      8: atan_q = 40'sd4194282;
      9: atan_q = 40'sd2097149;
      10: atan_q = 40'sd1048575;
      11: atan_q = 40'sd524287;
      12: atan_q = 40'sd262143;
      13: atan_q = 40'sd131071;
      14: atan_q = 40'sd65535;
      15: atan_q = 40'sd32767;
      16: atan_q = 40'sd16383;
      17: atan_q = 40'sd8191;
      18: atan_q = 40'sd4095;
      19: atan_q = 40'sd2047;
      20: atan_q = 40'sd1023;
      21: atan_q = 40'sd511;
      22: atan_q = 40'sd255;
      23: atan_q = 40'sd127;
      24: atan_q = 40'sd63;
      25: atan_q = 40'sd31;
      26: atan_q = 40'sd15;
      27: atan_q = 40'sd7;
      28: atan_q = 40'sd3;
      29: atan_q = 40'sd1;
      default: atan_q = '0;
    endcase
  endfunction
endpackage

// ===== design/hav_mul.sv =====
// Pipelined 32x64-bit unsigned multiplier split into two 32x32 partial products.
// Depends on nothing; stands alone.
module hav_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [63:0] b,
  output logic [95:0] p
);
  logic [63:0] lo, hi;
  always_ff @(posedge clk) begin
    if (en) begin
      lo <= a * b[31:0];
      hi <= a * b[63:32];
      p <= {hi, 32'd0} + {32'd0, lo};
    end
  end
endmodule

// ===== design/haversine_distance.sv =====
// Haversine great-circle distance: fully pipelined, one position pair per cycle while not stalled.
// Depends on hav_pkg and hav_mul.
module haversine_distance
  import hav_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        distance_m
);
  // Accepts one pair every cycle while not stalled; the pipeline depth is set by
  // the CORDIC stage count (sine/cosine and arctangent), two square roots of 31
  // steps each, and eleven stages of clamp, multiply, constant division and
  // rounding. A stall freezes the whole pipeline.
  localparam int L = 11 + 2 * NStg + 31;
  logic adv;
  logic [L-1:0] vld;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end
  assign out_valid = vld[L-1];

  // stage 0: clamp, differences, wrap
  logic signed [32:0] la0, lb0, dlat0, dlon0;
  logic signed [33:0] dl;
  always_comb begin
    dl = 34'(signed'(lon_b)) - 34'(signed'(lon_a));
    if (dl >= 34'sd1800000000) dl = dl - 34'sd3600000000;
    else if (dl < -34'sd1800000000) dl = dl + 34'sd3600000000;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      la0 <= (32'(lat_a) > LatMax) ? 33'(LatMax) :
             (32'(lat_a) < -LatMax) ? -33'(LatMax) : 33'(lat_a);
      lb0 <= (32'(lat_b) > LatMax) ? 33'(LatMax) :
             (32'(lat_b) < -LatMax) ? -33'(LatMax) : 33'(lat_b);
      dlon0 <= 33'(dl);
    end
  end
  always_comb dlat0 = lb0 - la0;

  // magnitude times pi (multiplier); latitudes doubled to share one divisor
  logic [31:0] mag [4];
  logic [3:0] neg1, neg2, neg3, neg4, neg5;
  logic [95:0] prod [4];
  always_comb begin
    mag[0] = 32'(dlat0[32] ? -dlat0 : dlat0);
    mag[1] = 32'(dlon0[32] ? -dlon0 : dlon0);
    mag[2] = 32'(la0[32] ? -la0 : la0) << 1;
    mag[3] = 32'(lb0[32] ? -lb0 : lb0) << 1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      neg1 <= {lb0[32], la0[32], dlon0[32], dlat0[32]};
      neg2 <= neg1;
      neg3 <= neg2;
      neg4 <= neg3;
      neg5 <= neg4;
    end
  end
  for (genvar k = 0; k < 4; k++) begin : g_m
    hav_mul u_m (.clk(clk), .en(adv), .a(mag[k]), .b({32'd0, PiQ}), .p(prod[k]));
  end

  // divide by constant 3600000000: reciprocal estimate, one correction step
  localparam logic [31:0] RecipD = 32'd2562047788;
  localparam logic [31:0] DivD = 32'd3600000000;
  logic [62:0] num [4];
  logic [63:0] qm [4];
  logic [62:0] nd1 [4], nd2 [4];
  logic [31:0] q0 [4];
  logic [63:0] qd [4];
  logic [63:0] rem [4];
  q_t th [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num[k] = prod[k][62:0] + 63'd1800000000;
      rem[k] = {1'b0, nd2[k]} - qd[k];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        qm[k] <= 64'(num[k][62:31]) * 64'(RecipD);
        nd1[k] <= num[k];
        q0[k] <= qm[k][63:32];
        qd[k] <= 64'(qm[k][63:32]) * 64'(DivD);
        nd2[k] <= nd1[k];
        th[k] <= DW'(q0[k]) + ((rem[k] >= 64'(DivD)) ? DW'(1) : DW'(0));
      end
    end
  end
  q_t ths [4];
  always_comb for (int k = 0; k < 4; k++) ths[k] = neg5[k] ? -th[k] : th[k];

  // rotation CORDIC stages, four lanes
  q_t rx [NStg+1][4], ry [NStg+1][4], rz [NStg+1][4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rx[0][k] = GainInv; ry[0][k] = '0; rz[0][k] = ths[k];
    end
  end
  for (genvar i = 0; i < NStg; i++) begin : g_r
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 4; k++) begin
          if (!rz[i][k][DW-1]) begin
            rx[i+1][k] <= rx[i][k] - (ry[i][k] >>> i);
            ry[i+1][k] <= ry[i][k] + (rx[i][k] >>> i);
            rz[i+1][k] <= rz[i][k] - atan_q(i);
          end else begin
            rx[i+1][k] <= rx[i][k] + (ry[i][k] >>> i);
            ry[i+1][k] <= ry[i][k] - (rx[i][k] >>> i);
            rz[i+1][k] <= rz[i][k] + atan_q(i);
          end
        end
      end
    end
  end

  function automatic q_t clmp(input q_t v, input q_t lo, input q_t hi);
    clmp = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction
  function automatic q_t rmul(input q_t p, input q_t q);
    logic [61:0] t;
    t = 62'(p[30:0]) * 62'(q[30:0]) + 62'd536870912;
    rmul = DW'(t[61:30]);
  endfunction

  // square-and-product stages
  q_t s1, s2, ca, cb, p1, p2, p3, af;
  q_t s1c, s2c;
  always_comb begin
    s1c = clmp(ry[NStg][0], -OneQ, OneQ);
    s2c = clmp(ry[NStg][1], -OneQ, OneQ);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1c[DW-1] ? -s1c : s1c;
      s2 <= s2c[DW-1] ? -s2c : s2c;
      ca <= clmp(rx[NStg][2], '0, OneQ);
      cb <= clmp(rx[NStg][3], '0, OneQ);
      p1 <= rmul(s1, s1);
      p2 <= rmul(ca, cb);
      p3 <= rmul(s2, s2);
      af <= clmp(p1 + rmul(p2, p3), '0, OneQ);
    end
  end

  // bit-serial square roots: 31 stages for a<<30 and (1-a)<<30 (61-bit values)
  localparam int SQ = 31;
  logic [61:0] sn [SQ+1][2];
  logic [61:0] sr [SQ+1][2];
  always_comb begin
    sn[0][0] = {af[31:0], 30'd0};
    sn[0][1] = {32'(OneQ - af), 30'd0};
    sr[0][0] = '0; sr[0][1] = '0;
  end
  for (genvar j = 0; j < SQ; j++) begin : g_s
    localparam logic [61:0] Bit = 62'd1 << (60 - 2 * j);
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 2; k++) begin
          if (sn[j][k] >= sr[j][k] + Bit) begin
            sn[j+1][k] <= sn[j][k] - (sr[j][k] + Bit);
            sr[j+1][k] <= (sr[j][k] >> 1) + Bit;
          end else begin
            sn[j+1][k] <= sn[j][k];
            sr[j+1][k] <= sr[j][k] >> 1;
          end
        end
      end
    end
  end

  // vectoring CORDIC
  q_t vx [NStg+1], vy [NStg+1], vz [NStg+1];
  always_comb begin
    vy[0] = DW'(sr[SQ][0]); vx[0] = DW'(sr[SQ][1]); vz[0] = '0;
  end
  for (genvar i = 0; i < NStg; i++) begin : g_v
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + atan_q(i);
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - atan_q(i);
        end
      end
    end
  end

  // scale to metres and saturate
  q_t zc;
  logic [54:0] dm;
  logic [24:0] dq;
  always_comb zc = clmp(vz[NStg], '0, HalfPi);
  always_ff @(posedge clk) begin
    if (adv) begin
      dm <= 55'(zc[30:0]) * 55'd12742000 + 55'd536870912;
      dq <= (dm[54:30] > DistMax) ? DistMax : dm[54:30];
    end
  end
  assign distance_m = dq;
endmodule

// ===== test/tb.sv =====
// Testbench for haversine_distance: random and directed position pairs, results
// checked against a fixed-point haversine predictor built in this file.
// Depends on hav_pkg and the haversine_distance design.
module tb;
  import hav_pkg::*;

  typedef struct packed {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [30:0] lat_a = '0;
  logic signed [31:0] lon_a = '0;
  logic signed [30:0] lat_b = '0;
  logic signed [31:0] lon_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [24:0] distance_m;

  pair_t pair_q[$];
  logic [24:0] dist_q[$];
  bit failed = 0;
  bit fill_done = 0;
  int tx_wait = 0;
  int rx_wait = 0;

  haversine_distance i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_tab(int i);
    longint t[32] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535,
      32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};
    return t[i];
  endfunction

  function automatic longint to_rad(longint u, longint dv);
    longint unsigned mag;
    longint unsigned q;
    mag = u < 0 ? -u : u;
    q = (mag * 64'd3373259426 + dv / 2) / dv;
    return u < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sine_abs(longint th, output longint cs);
    longint x, y, z, nx;
    x = 652032874; y = 0; z = th;
    for (int i = 0; i < NStg; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= atan_tab(i);
      end else begin
        nx = x + shr(y, i); y = y - shr(x, i); z += atan_tab(i);
      end
      x = nx;
    end
    cs = clamp(x, -1073741824, 1073741824);
    y = clamp(y, -1073741824, 1073741824);
    return y < 0 ? -y : y;
  endfunction

  function automatic longint root(longint unsigned n);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint mulq(longint p, longint q);
    return (p * q + 536870912) >>> 30;
  endfunction

  function automatic logic [24:0] great_circle_m(pair_t p);
    longint la, lb, dlat, dlon, s1, s2, ca, cb, a, x, y, z, nx, dmy;
    longint unsigned d;
    la = clamp(p.lat_a, -900000000, 900000000);
    lb = clamp(p.lat_b, -900000000, 900000000);
    dlat = lb - la;
    dlon = longint'(p.lon_b) - longint'(p.lon_a);
    if (dlon >= 1800000000) dlon -= 64'sd3600000000;
    else if (dlon < -1800000000) dlon += 64'sd3600000000;
    s1 = sine_abs(to_rad(dlat, 64'sd3600000000), dmy);
    s2 = sine_abs(to_rad(dlon, 64'sd3600000000), dmy);
    void'(sine_abs(to_rad(la, 1800000000), ca));
    void'(sine_abs(to_rad(lb, 1800000000), cb));
    ca = clamp(ca, 0, 1073741824);
    cb = clamp(cb, 0, 1073741824);
    a = clamp(mulq(s1, s1) + mulq(mulq(ca, cb), mulq(s2, s2)), 0, 1073741824);
    y = root(longint'(a) << 30);
    x = root(longint'(1073741824 - a) << 30);
    z = 0;
    for (int i = 0; i < NStg; i++) begin
      if (y > 0) begin
        nx = x + shr(y, i); y = y - shr(x, i); z += atan_tab(i);
      end else begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= atan_tab(i);
      end
      x = nx;
    end
    z = clamp(z, 0, 1686629713);
    d = (64'd6371000 * z * 2 + 64'd536870912) >> 30;
    if (d > 20015087) d = 20015087;
    return d[24:0];
  endfunction

  function automatic longint rnd_lat();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 900000000 : -900000000;
      1: return $signed(31'($urandom()));
      default: return longint'($urandom_range(0, 1800000000)) - 900000000;
    endcase
  endfunction

  function automatic longint rnd_lon();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 1800000000 : -1800000000;
      1: return $signed(32'($urandom()));
      default: return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    endcase
  endfunction

  task automatic add(longint la, longint oa, longint lb, longint ob);
    pair_t p;
    p.lat_a = la; p.lon_a = oa; p.lat_b = lb; p.lon_b = ob;
    pair_q.push_back(p);
  endtask

  initial begin
    longint la, oa;
    add(0, 0, 0, 0);
    add(900000000, 0, -900000000, 0);
    add(0, 0, 0, 1800000000);
    add(0, -1800000000, 0, 1800000000);
    add(0, 1799999999, 0, -1800000000);
    add(0, 0, 0, -1800000000);
    add(0, 0, 0, 1799999999);
    add(-1073741824, 0, 1073741823, 0);
    add(1073741823, 2147483647, -1073741824, -2147483648);
    add(-1073741824, -2147483648, 1073741823, 2147483647);
    add(300000000, 1000000000, 300000000, 1000000001);
    add(515000000, -1200000, 407000000, -740000000);
    add(-337000000, 1512000000, 515000000, -1200000);
    add(0, 900000000, 0, -900000000);
    add(450000000, 0, -450000000, 1800000000);
    add(900000000, 1234567, 900000000, -1750000000);
    for (int n = 0; n < 600; n++) begin
      la = rnd_lat(); oa = rnd_lon();
      if ($urandom_range(0, 3) == 0)
        add(la, oa, la + $signed($urandom_range(0, 2000)) - 1000,
            oa + $signed($urandom_range(0, 2000)) - 1000);
      else add(la, oa, rnd_lat(), rnd_lon());
    end
    fill_done = 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) dist_q.push_back(great_circle_m({lat_a, lon_a, lat_b, lon_b}));
      if (tx_wait > 0 || pair_q.size() == 0) begin
        in_valid <= 1'b0;
        if (tx_wait > 0) tx_wait <= tx_wait - 1;
      end else begin
        pair_t p;
        p = pair_q.pop_front();
        in_valid <= 1'b1;
        lat_a <= p.lat_a; lon_a <= p.lon_a; lat_b <= p.lat_b; lon_b <= p.lon_b;
        tx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (dist_q.size() == 0) begin
          $error("distance_m: no result expected, got %0d", distance_m);
          failed = 1;
        end else begin
          logic [24:0] e;
          e = dist_q.pop_front();
          if (e !== distance_m) begin
            $error("distance_m: expected %0d, got %0d", e, distance_m);
            failed = 1;
          end
        end
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait <= rx_wait - 1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall && $urandom_range(0, 2) == 0)
          rx_wait <= $urandom_range(0, 6);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (fill_done);
    while (pair_q.size() != 0 || in_valid || dist_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed && dist_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== files.f =====
design/hav_pkg.sv
design/hav_mul.sv
design/haversine_distance.sv
test/tb.sv
